// ===== hw/rtl/gpc_pkg.sv =====
// Shared types, constants and helper functions for the GMM policy classifier.
// No dependencies; imported by gpc_ctrl, gpc_dp and gmm_policy_classifier_top.
`default_nettype none
package gpc_pkg;

   localparam int NUM_FEATURES     = 6;
   localparam int NUM_CLUSTERS_DEF = 4;
   localparam int COEF_DEPTH_DEF   = 256;
   localparam int CLUSTER_BASE     = 12;
   localparam int CLUSTER_STRIDE   = 43;
   localparam int CHOL_OFFSET      = 6;
   localparam int BIAS_OFFSET      = 42;
   localparam int RATIO_MAX        = 10000;
   localparam int LN2_Q16          = 45426;

   localparam logic [1:0] POL_LRU   = 2'd0;
   localparam logic [1:0] NO_POLICY = 2'd3;

   localparam logic [1:0] CSR_POLICY_TABLE = 2'd0;
   localparam logic [1:0] CSR_VOTES_NEEDED = 2'd1;

   localparam logic [7:0] POLICY_TABLE_RST = 8'd25;
   localparam logic [3:0] VOTES_NEEDED_RST = 4'd5;

   typedef enum logic [3:0] {
      OP_NOP, OP_SUBM, OP_SCL, OP_DIF, OP_MAC, OP_SQ, OP_BIAS, OP_LMUL1, OP_LMUL2
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] j;
      logic [1:0] k;
      logic       first;
      logic       last;
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic       lz_step;
      logic       vote;
   } gpc_ctl_type;

   typedef struct packed {
      logic norm_done;
   } gpc_sts_type;

   // log2(1 + i/64) in Q16.16 by repeated squaring; entry 64 is exactly 1.0
   function automatic logic [16:0] log_entry(input int unsigned i);
      logic [63:0] m;
      logic [16:0] r;
      m = 64'(64 + i) << 24;
      r = '0;
      for (int b = 0; b < 16; b++) begin
         m = (m * m) >> 30;
         r = {r[15:0], 1'b0};
         if (m >= (64'd2 << 30)) begin
            r[0] = 1'b1;
            m    = m >> 1;
         end
      end
      if (i >= 64) begin
         r = 17'd65536;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
      logic signed [31:0] res;
      if (x > 52'sd2147483647) begin
         res = 32'sh7fffffff;
      end else if (x < -52'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gpc_ctrl.sv =====
// Sequencer for the GMM policy classifier: issues at most one datapath command per cycle.
// Depends on gpc_pkg.
`default_nettype none
module gpc_ctrl
   import gpc_pkg::*;
#(
   parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF,
   parameter int COEF_DEPTH   = COEF_DEPTH_DEF,
   localparam int AW          = $clog2(COEF_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          req_operation,
   input  var  gpc_sts_type   sts,
   output var  gpc_ctl_type   ctl,
   output      logic [AW-1:0] rd_addr,
   output      logic          busy
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_NORM, ST_LOG1, ST_LOGW, ST_LOG2, ST_SCALE, ST_DIFF, ST_MAC,
      ST_MACW, ST_SQ, ST_BIAS, ST_DRN1, ST_DRN2, ST_VOTE
   } state_type;

   localparam logic [1:0] LAST_K = 2'(NUM_CLUSTERS - 1);
   localparam logic [2:0] LAST_J = 3'(NUM_FEATURES - 1);

   state_type  state_ff, state_in;
   logic [2:0] j_ff, j_in, m_ff, m_in;
   logic [1:0] k_ff, k_in;
   logic       phase_ff, phase_in;
   int         base;
   int         addr;

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      m_in     = m_ff;
      k_in     = k_ff;
      phase_in = phase_ff;
      ctl      = '0;
      ctl.cmd.op = OP_NOP;
      ctl.cmd.j  = j_ff;
      ctl.cmd.k  = k_ff;
      base     = CLUSTER_BASE + CLUSTER_STRIDE * int'(k_ff);
      addr     = 0;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_operation) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (sts.norm_done) begin
               state_in = ST_LOG1;
            end else begin
               ctl.lz_step = 1'b1;
            end
         end
         ST_LOG1: begin
            ctl.cmd.op = OP_LMUL1;
            state_in   = ST_LOGW;
         end
         ST_LOGW: begin
            state_in = ST_LOG2;
         end
         ST_LOG2: begin
            ctl.cmd.op = OP_LMUL2;
            j_in       = '0;
            phase_in   = 1'b0;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            if (!phase_ff) begin
               ctl.cmd.op = OP_SUBM;
               addr       = int'(j_ff);
               phase_in   = 1'b1;
            end else begin
               ctl.cmd.op = OP_SCL;
               addr       = NUM_FEATURES + int'(j_ff);
               phase_in   = 1'b0;
               if (j_ff == LAST_J) begin
                  j_in     = '0;
                  k_in     = '0;
                  state_in = ST_DIFF;
               end else begin
                  j_in = j_ff + 3'd1;
               end
            end
         end
         ST_DIFF: begin
            ctl.cmd.op = OP_DIF;
            addr       = base + int'(j_ff);
            if (j_ff == LAST_J) begin
               j_in     = '0;
               m_in     = '0;
               state_in = ST_MAC;
            end else begin
               j_in = j_ff + 3'd1;
            end
         end
         ST_MAC: begin
            ctl.cmd.op    = OP_MAC;
            ctl.cmd.first = (j_ff == 3'd0);
            ctl.cmd.last  = (j_ff == LAST_J);
            addr = base + CHOL_OFFSET + int'(j_ff) * NUM_FEATURES + int'(m_ff);
            if (j_ff == LAST_J) begin
               j_in     = '0;
               state_in = ST_MACW;
            end else begin
               j_in = j_ff + 3'd1;
            end
         end
         ST_MACW: begin
            state_in = ST_SQ;
         end
         ST_SQ: begin
            ctl.cmd.op    = OP_SQ;
            ctl.cmd.first = (m_ff == 3'd0);
            if (m_ff == LAST_J) begin
               state_in = ST_BIAS;
            end else begin
               m_in     = m_ff + 3'd1;
               state_in = ST_MAC;
            end
         end
         ST_BIAS: begin
            ctl.cmd.op = OP_BIAS;
            addr       = base + BIAS_OFFSET;
            j_in       = '0;
            m_in       = '0;
            if (k_ff == LAST_K) begin
               state_in = ST_DRN1;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_DIFF;
            end
         end
         ST_DRN1: state_in = ST_DRN2;
         ST_DRN2: state_in = ST_VOTE;
         ST_VOTE: begin
            ctl.vote = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rd_addr = AW'(addr);
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         m_ff     <= '0;
         k_ff     <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         m_ff     <= m_in;
         k_ff     <= k_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/gpc_dp.sv =====
// Datapath of the GMM policy classifier: coefficient memory, shared multiplier,
// log unit, score compare and vote hysteresis. Depends on gpc_pkg.
`default_nettype none
module gpc_dp
   import gpc_pkg::*;
#(
   parameter int COEF_DEPTH = COEF_DEPTH_DEF,
   localparam int AW        = $clog2(COEF_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic          req_operation,
   input  wire logic [7:0]    req_coef_index,
   input  wire logic [31:0]   req_coef_value,
   input  wire logic [31:0]   req_seq_ratio,
   input  wire logic [31:0]   req_avg_reuse_interval,
   input  wire logic [31:0]   req_unique_ratio,
   input  wire logic [31:0]   req_short_reuse_ratio,
   input  wire logic [31:0]   req_mid_reuse_ratio,
   input  wire logic [31:0]   req_long_reuse_ratio,
   input  var  gpc_ctl_type   ctl,
   input  wire logic [AW-1:0] rd_addr,
   output var  gpc_sts_type   sts,
   input  wire logic          csr_valid,
   input  wire logic [1:0]    csr_index,
   input  wire logic [7:0]    csr_wdata,
   output      logic          rsp_valid,
   output      logic [1:0]    rsp_cluster,
   output      logic [1:0]    rsp_target_policy,
   output      logic [1:0]    rsp_active_policy,
   output      logic          rsp_policy_changed,
   output      logic [3:0]    rsp_vote_count
);

   logic [31:0]        mem [COEF_DEPTH];
   logic signed [31:0] rdata_ff;
   logic [16:0]        log_tab [0:64];

   dp_cmd_type         cmd1_ff, cmd2_ff;
   logic signed [31:0] data2_ff;
   logic signed [64:0] prod_ff;
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;

   logic signed [31:0] feat_ff   [NUM_FEATURES];
   logic signed [31:0] scaled_ff [NUM_FEATURES];
   logic signed [31:0] diff_ff   [NUM_FEATURES];
   logic signed [32:0] tmp_ff;
   logic signed [50:0] acc_ff, sum_ff, best_ff;
   logic signed [31:0] y_ff;
   logic [1:0]         best_k_ff;
   logic [32:0]        norm_ff;
   logic [5:0]         lz_p_ff;
   logic [22:0]        lg2_ff;

   logic [7:0]         tbl_ff;
   logic [3:0]         need_cfg_ff;
   logic [1:0]         active_ff, cand_ff;
   logic [3:0]         cnt_ff;
   logic               rsp_valid_ff, changed_ff;
   logic [1:0]         cluster_ff, target_ff;

   logic [5:0]         idx;
   logic [15:0]        rem;
   logic [16:0]        t_step;
   logic signed [48:0] term;
   logic signed [50:0] acc_in, sum_in, score;
   logic [1:0]         tgt;
   logic [3:0]         need;
   logic [1:0]         active_in, cand_in;
   logic [3:0]         cnt_in;
   logic               chg_in;

   for (genvar g = 0; g <= 64; g++) begin : g_log
      assign log_tab[g] = log_entry(g);
   end

   function automatic logic [31:0] ratio_q16(input logic [31:0] r);
      logic [13:0] s;
      s = (r > 32'(RATIO_MAX)) ? 14'(RATIO_MAX) : r[13:0];
      return 32'(s) << 16;
   endfunction

   // coefficient memory: load on accept, one registered read port
   always_ff @(posedge clock) begin
      if (accept && !req_operation && (32'(req_coef_index) < 32'(COEF_DEPTH))) begin
         mem[AW'(req_coef_index)] <= req_coef_value;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign sts.norm_done = norm_ff[32];

   assign idx    = norm_ff[31:26];
   assign rem    = norm_ff[25:10];
   assign t_step = log_tab[7'(idx) + 7'd1] - log_tab[7'(idx)];

   // multiplier operand select, stage 1
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd1_ff.op)
         OP_SCL: begin
            mul_a = tmp_ff;
            mul_b = rdata_ff;
         end
         OP_MAC: begin
            mul_a = {diff_ff[cmd1_ff.j][31], diff_ff[cmd1_ff.j]};
            mul_b = rdata_ff;
         end
         OP_SQ: begin
            mul_a = {y_ff[31], y_ff};
            mul_b = y_ff;
         end
         OP_LMUL1: begin
            mul_a = 33'(t_step);
            mul_b = 32'(rem);
         end
         OP_LMUL2: begin
            mul_a = 33'(lg2_ff);
            mul_b = 32'(LN2_Q16);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign term   = prod_ff[64:16];
   assign acc_in = (cmd2_ff.first ? 51'sd0 : acc_ff) + {{2{term[48]}}, term};
   assign sum_in = (cmd2_ff.first ? 51'sd0 : sum_ff) + {{2{term[48]}}, term};
   assign score  = {{19{data2_ff[31]}}, data2_ff} - {sum_ff[50], sum_ff[50:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd1_ff <= '0;
         cmd2_ff <= '0;
      end else begin
         cmd1_ff <= ctl.cmd;
         cmd2_ff <= cmd1_ff;
      end
      prod_ff  <= mul_a * mul_b;
      data2_ff <= rdata_ff;

      // capture features on a classify request
      if (accept && req_operation) begin
         feat_ff[0] <= ratio_q16(req_seq_ratio);
         feat_ff[1] <= '0;
         feat_ff[2] <= ratio_q16(req_unique_ratio);
         feat_ff[3] <= ratio_q16(req_short_reuse_ratio);
         feat_ff[4] <= ratio_q16(req_mid_reuse_ratio);
         feat_ff[5] <= ratio_q16(req_long_reuse_ratio);
         norm_ff    <= 33'(req_avg_reuse_interval) + 33'd1;
         lz_p_ff    <= 6'd32;
      end else if (ctl.lz_step) begin
         norm_ff <= {norm_ff[31:0], 1'b0};
         lz_p_ff <= lz_p_ff - 6'd1;
      end

      // stage 1 writes
      case (cmd1_ff.op)
         OP_SUBM: tmp_ff <= {feat_ff[cmd1_ff.j][31], feat_ff[cmd1_ff.j]}
                            - {rdata_ff[31], rdata_ff};
         OP_DIF: diff_ff[cmd1_ff.j] <= sat32(52'(scaled_ff[cmd1_ff.j]) - 52'(rdata_ff));
         default: ;
      endcase

      // stage 2 writes
      case (cmd2_ff.op)
         OP_SCL: scaled_ff[cmd2_ff.j] <= sat32({{3{term[48]}}, term});
         OP_MAC: begin
            acc_ff <= acc_in;
            if (cmd2_ff.last) begin
               y_ff <= sat32({acc_in[50], acc_in});
            end
         end
         OP_SQ: sum_ff <= sum_in;
         OP_BIAS: begin
            if (cmd2_ff.k == 2'd0 || score > best_ff) begin
               best_ff   <= score;
               best_k_ff <= cmd2_ff.k;
            end
         end
         OP_LMUL1: lg2_ff <= {1'b0, lz_p_ff, 16'b0} + 23'(log_tab[7'(idx)])
                             + 23'(prod_ff[31:16]);
         OP_LMUL2: feat_ff[1] <= prod_ff[47:16];
         default: ;
      endcase
   end

   // vote hysteresis
   always_comb begin
      tgt = tbl_ff[{best_k_ff, 1'b0} +: 2];
      if (tgt == NO_POLICY) begin
         tgt = POL_LRU;
      end
      need      = (need_cfg_ff == 4'd0) ? 4'd1 : need_cfg_ff;
      active_in = active_ff;
      cand_in   = cand_ff;
      cnt_in    = cnt_ff;
      chg_in    = 1'b0;
      if (tgt == active_ff) begin
         cnt_in  = '0;
         cand_in = NO_POLICY;
      end else begin
         if (tgt == cand_ff) begin
            if (cnt_ff != 4'd15) begin
               cnt_in = cnt_ff + 4'd1;
            end
         end else begin
            cand_in = tgt;
            cnt_in  = 4'd1;
         end
         if (cnt_in >= need) begin
            active_in = tgt;
            cand_in   = NO_POLICY;
            cnt_in    = '0;
            chg_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_ff       <= POLICY_TABLE_RST;
         need_cfg_ff  <= VOTES_NEEDED_RST;
         active_ff    <= NO_POLICY;
         cand_ff      <= NO_POLICY;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == CSR_POLICY_TABLE) begin
            tbl_ff <= csr_wdata;
         end
         if (csr_valid && csr_index == CSR_VOTES_NEEDED) begin
            need_cfg_ff <= csr_wdata[3:0];
         end
         rsp_valid_ff <= ctl.vote;
         if (ctl.vote) begin
            active_ff <= active_in;
            cand_ff   <= cand_in;
            cnt_ff    <= cnt_in;
         end
      end
      if (ctl.vote) begin
         cluster_ff <= best_k_ff;
         target_ff  <= tgt;
         changed_ff <= chg_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cluster        = cluster_ff;
   assign rsp_target_policy  = target_ff;
   assign rsp_active_policy  = active_ff;
   assign rsp_policy_changed = changed_ff;
   assign rsp_vote_count     = cnt_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/gmm_policy_classifier_top.sv =====
// GMM policy classifier top level: joins the sequencer and the datapath.
// Depends on gpc_pkg, gpc_ctrl and gpc_dp.
// A load request writes one coefficient and gives no response; loads may follow
// one another every cycle. A classify request first runs a leading-one search on
// interval + 1, then scores every cluster with one shared multiplier issuing at most
// one product a cycle. rsp_valid is high for one cycle, and busy drops in that same
// cycle, so the next request can be taken in that cycle. The receiver cannot stall.
// Synchronous reset clears control and policy state and returns the registers to
// their defaults; the coefficient memory keeps whatever it held and must be loaded
// before use.
`default_nettype none
module gmm_policy_classifier_top
   import gpc_pkg::*;
#(
   parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF,
   parameter int COEF_DEPTH   = COEF_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_coef_index,
   input  wire logic [31:0] req_coef_value,
   input  wire logic [31:0] req_seq_ratio,
   input  wire logic [31:0] req_avg_reuse_interval,
   input  wire logic [31:0] req_unique_ratio,
   input  wire logic [31:0] req_short_reuse_ratio,
   input  wire logic [31:0] req_mid_reuse_ratio,
   input  wire logic [31:0] req_long_reuse_ratio,
   // response channel
   output      logic        rsp_valid,
   output      logic [1:0]  rsp_cluster,
   output      logic [1:0]  rsp_target_policy,
   output      logic [1:0]  rsp_active_policy,
   output      logic        rsp_policy_changed,
   output      logic [3:0]  rsp_vote_count,
   // register write channel
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int AW = $clog2(COEF_DEPTH);

   gpc_ctl_type   ctl;
   gpc_sts_type   sts;
   logic [AW-1:0] rd_addr;
   logic          accept;

   // take a request only while the sequencer is idle
   assign accept    = start && !busy;
   // register writes land at once
   assign csr_ready = 1'b1;

   gpc_ctrl #(
      .NUM_CLUSTERS (NUM_CLUSTERS),
      .COEF_DEPTH   (COEF_DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .sts           (sts),
      .ctl           (ctl),
      .rd_addr       (rd_addr),
      .busy          (busy)
   );

   gpc_dp #(
      .COEF_DEPTH (COEF_DEPTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .accept                 (accept),
      .req_operation          (req_operation),
      .req_coef_index         (req_coef_index),
      .req_coef_value         (req_coef_value),
      .req_seq_ratio          (req_seq_ratio),
      .req_avg_reuse_interval (req_avg_reuse_interval),
      .req_unique_ratio       (req_unique_ratio),
      .req_short_reuse_ratio  (req_short_reuse_ratio),
      .req_mid_reuse_ratio    (req_mid_reuse_ratio),
      .req_long_reuse_ratio   (req_long_reuse_ratio),
      .ctl                    (ctl),
      .rd_addr                (rd_addr),
      .sts                    (sts),
      .csr_valid              (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .rsp_valid              (rsp_valid),
      .rsp_cluster            (rsp_cluster),
      .rsp_target_policy      (rsp_target_policy),
      .rsp_active_policy      (rsp_active_policy),
      .rsp_policy_changed     (rsp_policy_changed),
      .rsp_vote_count         (rsp_vote_count)
   );

endmodule
`default_nettype wire

// ===== bench/tb_gmm_policy_classifier_top.sv =====
// Self-checking bench for gmm_policy_classifier_top: coefficient loads and classify requests,
// predicted in-bench and compared field by field. Depends on gpc_pkg and the top-level RTL.
`default_nettype none
module tb_gmm_policy_classifier_top;
   import gpc_pkg::*;

   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;
   localparam int   NUM_CLUST    = 4;
   localparam int   STORE_USED   = CLUSTER_BASE + CLUSTER_STRIDE * NUM_CLUST;
   localparam int   SETTLE       = 400;

   typedef struct {
      logic        op;
      logic [7:0]  idx;
      logic [31:0] val;
      logic [31:0] stat [6];   // seq, avg interval, unique, short, mid, long
   } request_type;

   typedef struct packed {
      logic [1:0] cluster;
      logic [1:0] target;
      logic [1:0] active;
      logic       changed;
      logic [3:0] votes;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = 1'b0;
   logic [7:0]  req_coef_index = '0;
   logic [31:0] req_coef_value = '0;
   logic [31:0] req_seq_ratio = '0, req_avg_reuse_interval = '0, req_unique_ratio = '0;
   logic [31:0] req_short_reuse_ratio = '0, req_mid_reuse_ratio = '0;
   logic [31:0] req_long_reuse_ratio = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_cluster, rsp_target_policy, rsp_active_policy;
   logic        rsp_policy_changed;
   logic [3:0]  rsp_vote_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   gmm_policy_classifier_top u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Mirror of the block's state, updated as requests and register writes are accepted
   // ---------------------------------------------------------------------------------
   logic [31:0] coef_mirror [256];
   logic [1:0]  active_pol = NO_POLICY;
   logic [1:0]  cand_pol   = NO_POLICY;
   logic [3:0]  vote_ctr   = '0;
   logic [7:0]  pol_table  = POLICY_TABLE_RST;
   logic [3:0]  votes_req  = VOTES_NEEDED_RST;
   longint unsigned log2_frac [65];

   request_type pending_reqs [$];
   verdict_type awaited [$];
   int       fails = 0;
   int       mismatches = 0;

   // log2(1 + i/64) in Q16.16 by repeated squaring of the mantissa, truncating
   initial begin
      longint unsigned m;
      for (int i = 0; i < 64; i++) begin
         m = longint'(64 + i) << 24;
         log2_frac[i] = 0;
         for (int b = 0; b < 16; b++) begin
            m = (m * m) >> 30;
            log2_frac[i] = log2_frac[i] << 1;
            if (m >= (64'd2 << 30)) begin
               log2_frac[i] = log2_frac[i] | 1;
               m = m >> 1;
            end
         end
      end
      log2_frac[64] = 65536;
   end

   function automatic longint word(int addr);
      return longint'($signed(coef_mirror[addr]));
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint ln1p_q16(logic [31:0] x);
      longint unsigned v, frac, idx, rem, lg2;
      int p;
      v = longint'(x) + 1;
      p = 0;
      while (p < 40 && (v >> (p + 1)) != 0) p++;
      frac = (v << (32 - p)) & 64'hFFFF_FFFF;
      idx  = frac >> 26;
      rem  = (frac >> 10) & 64'hFFFF;
      lg2  = (longint'(p) << 16) + log2_frac[idx]
             + (((log2_frac[idx + 1] - log2_frac[idx]) * rem) >> 16);
      return longint'((lg2 * LN2_Q16) >> 16);
   endfunction

   function automatic longint ratio_q16(logic [31:0] r);
      return (r > RATIO_MAX) ? (longint'(RATIO_MAX) << 16) : (longint'(r) << 16);
   endfunction

   // Score every component, pick the first maximum, then run the vote hysteresis
   function automatic verdict_type classify_window(request_type rq);
      longint feat [6], scaled [6], diff [6], y, acc, sum, score, best_score;
      int base;
      logic [3:0] need;
      verdict_type vd;
      best_score = 0;
      vd = '0;
      for (int j = 0; j < 6; j++)
         feat[j] = (j == 1) ? ln1p_q16(rq.stat[j]) : ratio_q16(rq.stat[j]);
      for (int j = 0; j < 6; j++)
         scaled[j] = clip32(((feat[j] - word(j)) * word(NUM_FEATURES + j)) >>> 16);
      for (int k = 0; k < NUM_CLUST; k++) begin
         base = CLUSTER_BASE + CLUSTER_STRIDE * k;
         sum = 0;
         for (int j = 0; j < 6; j++) diff[j] = clip32(scaled[j] - word(base + j));
         for (int m = 0; m < 6; m++) begin
            acc = 0;
            for (int j = 0; j < 6; j++)
               acc += (diff[j] * word(base + CHOL_OFFSET + j * 6 + m)) >>> 16;
            y = clip32(acc);
            sum += (y * y) >>> 16;
         end
         score = word(base + BIAS_OFFSET) - (sum >>> 1);
         if (k == 0 || score > best_score) begin
            best_score = score;
            vd.cluster = 2'(k);
         end
      end
      vd.target = pol_table[2 * vd.cluster +: 2];
      if (vd.target == 2'd3) vd.target = POL_LRU;
      need = (votes_req == 0) ? 4'd1 : votes_req;
      if (vd.target == active_pol) begin
         vote_ctr = '0;
         cand_pol = NO_POLICY;
      end else begin
         if (vd.target == cand_pol) begin
            if (vote_ctr < 4'd15) vote_ctr++;
         end else begin
            cand_pol = vd.target;
            vote_ctr = 4'd1;
         end
         if (vote_ctr >= need) begin
            active_pol = vd.target;
            cand_pol   = NO_POLICY;
            vote_ctr   = '0;
            vd.changed = 1'b1;
         end
      end
      vd.active = active_pol;
      vd.votes  = vote_ctr;
      return vd;
   endfunction

   // ---------------------------------------------------------------------------------
   // Driver: wait the drawn gap, pop a request, hold start until the block takes it
   // ---------------------------------------------------------------------------------
   request_type cur;
   int       gap = 0;
   int       req_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap   <= 0;
      end else if (start && !busy) begin
         // request accepted: update the mirror and predict the response
         if (cur.op == REQ_LOAD) begin
            coef_mirror[cur.idx] = cur.val;
         end else begin
            awaited.push_back(classify_window(cur));
         end
         req_count++;
         start <= 1'b0;
         // long runs of requests with no drawn gap alternate with randomly idled ones
         gap <= ((req_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 16);
      end else if (!start) begin
         if (gap > 0) begin
            gap <= gap - 1;
         end else if (pending_reqs.size() != 0) begin
            cur = pending_reqs.pop_front();
            req_operation          <= cur.op;
            req_coef_index         <= cur.idx;
            req_coef_value         <= cur.val;
            req_seq_ratio          <= cur.stat[0];
            req_avg_reuse_interval <= cur.stat[1];
            req_unique_ratio       <= cur.stat[2];
            req_short_reuse_ratio  <= cur.stat[3];
            req_mid_reuse_ratio    <= cur.stat[4];
            req_long_reuse_ratio   <= cur.stat[5];
            start <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: every strobed response must match the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      verdict_type exp_v, got_v;
      if (!reset && rsp_valid) begin
         got_v = {rsp_cluster, rsp_target_policy, rsp_active_policy,
                  rsp_policy_changed, rsp_vote_count};
         if (awaited.size() == 0) begin
            fails++;
            $display("unexpected response: %p", got_v);
         end else begin
            exp_v = awaited.pop_front();
            if (got_v !== exp_v) begin
               fails++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected cluster %0d target %0d active %0d chg %0d votes %0d, got cluster %0d target %0d active %0d chg %0d votes %0d",
                           exp_v.cluster, exp_v.target, exp_v.active, exp_v.changed,
                           exp_v.votes, got_v.cluster, got_v.target, got_v.active,
                           got_v.changed, got_v.votes);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   task automatic queue_load(int addr, logic [31:0] value);
      request_type rq;
      rq.op  = REQ_LOAD;
      rq.idx = 8'(addr);
      rq.val = value;
      for (int j = 0; j < 6; j++) rq.stat[j] = $urandom;   // ignored on a load
      pending_reqs.push_back(rq);
   endtask

   task automatic queue_classify(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                                 logic [31:0] s3, logic [31:0] s4, logic [31:0] s5);
      request_type rq;
      rq.op  = REQ_CLASSIFY;
      rq.idx = 8'($urandom);
      rq.val = $urandom;
      rq.stat[0] = s0; rq.stat[1] = s1; rq.stat[2] = s2;
      rq.stat[3] = s3; rq.stat[4] = s4; rq.stat[5] = s5;
      pending_reqs.push_back(rq);
   endtask

   // plausible coefficient for an address, so that the winning cluster varies
   function automatic logic [31:0] sane_coef(int addr);
      int off;
      if (addr < 6)
         return (addr == 1) ? $urandom_range(0, 20 << 16) : $urandom_range(0, 10000 << 16);
      if (addr < 12)
         return (addr == 7) ? $urandom_range(5000, 20000) : $urandom_range(10, 60);
      if (addr >= STORE_USED) return $urandom;
      off = (addr - CLUSTER_BASE) % CLUSTER_STRIDE;
      if (off < CHOL_OFFSET) return 32'($signed($urandom_range(0, 6 << 16)) - (3 << 16));
      if (off < BIAS_OFFSET) return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
   endfunction

   function automatic logic [31:0] draw_ratio();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return $urandom;
         2:       return 32'(RATIO_MAX) + $urandom_range(0, 1);
         default: return $urandom_range(0, RATIO_MAX);
      endcase
   endfunction

   task automatic queue_random_window();
      queue_classify(draw_ratio(), $urandom >> $urandom_range(0, 31), draw_ratio(),
                     draw_ratio(), draw_ratio(), draw_ratio());
   endtask

   task automatic reload_store();
      for (int a = 0; a < STORE_USED; a++) queue_load(a, sane_coef(a));
   endtask

   // hold until the block is idle and every predicted response has arrived
   task automatic drain();
      while (pending_reqs.size() != 0 || start || awaited.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_POLICY_TABLE) pol_table = value;
      else if (index == CSR_VOTES_NEEDED) votes_req = value[3:0];
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------------------
   initial begin
      logic [7:0] tables [8];
      logic [3:0] votes [8];
      tables = '{8'd25, 8'd0, 8'd255, 8'b10_01_00_10, 8'd228, 8'd27, 8'd141, 8'd99};
      votes  = '{4'd5, 4'd1, 4'd15, 4'd0, 4'd2, 4'd3, 4'd7, 4'd4};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill the store first: no classify may read an unwritten word
      reload_store();
      queue_load(200, 32'h8000_0000);
      queue_load(255, 32'h7FFF_FFFF);
      // field extremes and saturation edges
      queue_classify('0, '0, '0, '0, '0, '0);
      queue_classify('1, '1, '1, '1, '1, '1);
      queue_classify(RATIO_MAX, 32'd1, RATIO_MAX, RATIO_MAX, RATIO_MAX, RATIO_MAX);
      queue_classify(RATIO_MAX + 1, 32'h8000_0000, RATIO_MAX + 1, 0, RATIO_MAX + 1, 0);
      queue_classify(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h5555_5555);
      for (int i = 0; i < 6; i++) queue_random_window();
      drain();

      // score tie: zero Cholesky and equal biases leave all scores equal, lowest wins
      for (int k = 0; k < NUM_CLUST; k++)
         for (int w = CHOL_OFFSET; w <= BIAS_OFFSET; w++)
            queue_load(CLUSTER_BASE + CLUSTER_STRIDE * k + w,
                       (w == BIAS_OFFSET) ? 32'h0001_0000 : 32'h0);
      for (int i = 0; i < 3; i++) queue_random_window();
      // largest bias on the last cluster, smallest on the first
      queue_load(CLUSTER_BASE + CLUSTER_STRIDE * 3 + BIAS_OFFSET, 32'h7FFF_FFFF);
      queue_load(CLUSTER_BASE + BIAS_OFFSET, 32'h8000_0000);
      for (int i = 0; i < 3; i++) queue_random_window();
      drain();

      // random phases, each under its own register settings
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_POLICY_TABLE, tables[ph]);
         write_csr(CSR_VOTES_NEEDED, {4'd0, votes[ph]});
         if (ph % 3 == 0) reload_store();
         for (int i = 0; i < 90; i++) begin
            if ($urandom_range(0, 9) == 0)
               queue_load($urandom_range(0, 255),
                          ($urandom_range(0, 7) == 0) ? $urandom
                                                      : sane_coef($urandom_range(0, 255)));
            else
               queue_random_window();
         end
         drain();
      end

      if (fails == 0 && awaited.size() == 0) begin
         $display("tb_gmm_policy_classifier_top: PASS");
      end else begin
         $display("tb_gmm_policy_classifier_top: FAIL");
      end
      $finish;
   end

   // generous overall limit
   initial begin
      #60_000_000;
      $display("tb_gmm_policy_classifier_top: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
